### rtl/efa_pkg.sv
package efa_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned SIZE_W = 24;
    localparam int unsigned TOP_W  = 33;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_ALIGNED = 2'd1,
        CMD_FREE    = 2'd2,
        CMD_INIT    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OOM  = 2'd1,
        ST_DROP = 2'd2
    } t_status;

    typedef enum logic {
        CFG_HEAP_START = 1'b0,
        CFG_HEAP_LIMIT = 1'b1
    } t_cfg_idx;

    // One free table entry: block address and size in 4-byte words.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } t_entry;

    // Operands and mode of the shared adder.
    typedef struct packed {
        logic [TOP_W-1:0] a;
        logic [TOP_W-1:0] b;
        logic             sub;
    } t_alu_op;

    typedef struct packed {
        logic [TOP_W-1:0] sum;
        logic             carry;
    } t_alu_res;

endpackage

### rtl/efa_alu.sv
module efa_alu
    import efa_pkg::*;
(
    input  t_alu_op  i_op,
    output t_alu_res o_res
);

    logic [TOP_W:0] w_full;

    // Subtraction is a + ~b + 1; the carry out is then set when a >= b.
    always_comb begin
        if (i_op.sub) begin
            w_full = {1'b0, i_op.a} + {1'b0, ~i_op.b} + {{TOP_W{1'b0}}, 1'b1};
        end else begin
            w_full = {1'b0, i_op.a} + {1'b0, i_op.b};
        end
    end

    assign o_res.sum   = w_full[TOP_W-1:0];
    assign o_res.carry = w_full[TOP_W];

endmodule

### rtl/efa_table.sv
module efa_table
    import efa_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned IDX_W = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_entry           i_wentry,
    input  logic [IDX_W-1:0] i_raddr,
    output t_entry           o_rentry
);

    t_entry r_mem [DEPTH];
    t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wentry;
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_rentry = r_rd;

endmodule

### rtl/exact_fit_free_list_allocator.sv
// Free and init go from idle straight to the output state. Allocate searches the table newest
// entry first and on a hit moves the newer entries down; on a miss it aligns and bumps the top
// pointer, and a nonzero alignment gap goes back to the table unless the table is full.
// All top pointer arithmetic goes through one shared 33-bit adder, one step a cycle.
// One request at a time; a new request is taken once the result has been taken.
// Synchronous active-low reset clears the state, top pointer, heap start and limit and fill count.
module exact_fit_free_list_allocator
    import efa_pkg::*;
#(
    parameter int unsigned FREE_SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [ADDR_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_cmd,
    input  logic [SIZE_W-1:0] i_req_size,
    input  logic [4:0]        i_align_log2,
    input  logic [ADDR_W-1:0] i_block_address,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [ADDR_W-1:0] o_result_address,
    output logic [1:0]        o_status
);

    localparam int unsigned IDX_W = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int unsigned CNT_W = $clog2(FREE_SLOTS + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SRCH  = 9'b000000010,
        S_SHIFT = 9'b000000100,
        S_ALIGN = 9'b000001000,
        S_GAP   = 9'b000010000,
        S_GAPW  = 9'b000100000,
        S_BUMP  = 9'b001000000,
        S_CHK   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [TOP_W-1:0]   r_top, n_top;
    logic [TOP_W-1:0]   r_aln, n_aln;
    logic [TOP_W-1:0]   r_tmp, n_tmp;
    logic [ADDR_W-1:0]  r_heap_start, r_heap_limit;
    logic [SIZE_W-1:0]  r_words, n_words;
    logic [ADDR_W-1:0]  r_amask, n_amask;
    logic               r_dropped, n_dropped;
    logic [ADDR_W-1:0]  r_result, n_result;
    logic [1:0]         r_status, n_status;

    logic               w_in_acc;
    logic               w_full;
    logic [SIZE_W:0]    w_round;
    logic [SIZE_W-1:0]  w_words;
    logic [ADDR_W-1:0]  w_amask;
    logic               w_hit;
    logic               w_more;
    logic               w_tail;

    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic [IDX_W-1:0]   w_raddr;
    t_entry             w_wentry;
    t_entry             w_rentry;
    t_alu_op            w_alu_op;
    t_alu_res           w_alu_res;

    efa_alu u_alu (
        .i_op  (w_alu_op),
        .o_res (w_alu_res)
    );

    efa_table #(
        .DEPTH (FREE_SLOTS),
        .IDX_W (IDX_W)
    ) u_table (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_waddr),
        .i_wentry (w_wentry),
        .i_raddr  (w_raddr),
        .o_rentry (w_rentry)
    );

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = (r_state == S_OUT);
    assign o_result_address = r_result;
    assign o_status         = r_status;

    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_full   = (r_cnt == CNT_W'(FREE_SLOTS));
    assign w_round  = {1'b0, i_req_size} + (SIZE_W + 1)'(3);
    assign w_words  = SIZE_W'(w_round[SIZE_W:2]);
    assign w_amask  = (i_cmd == CMD_ALIGNED) ? ~({ADDR_W{1'b1}} << i_align_log2) : '0;

    assign w_hit  = (w_rentry.size == r_words) && ((w_rentry.addr & r_amask) == '0);
    // After a hit at r_idx, a newer entry above it still has to move down.
    assign w_tail = ((CNT_W + 1)'(r_idx) + (CNT_W + 1)'(1)) < (CNT_W + 1)'(r_cnt);
    assign w_more = ((CNT_W + 1)'(r_idx) + (CNT_W + 1)'(2)) < (CNT_W + 1)'(r_cnt);

    // Operand selection for the shared adder.
    always_comb begin
        w_alu_op = '0;
        unique case (r_state)
            S_ALIGN: begin
                w_alu_op.a = r_top;
                w_alu_op.b = {1'b0, r_amask};
            end
            S_GAP: begin
                w_alu_op.a   = r_aln;
                w_alu_op.b   = r_top;
                w_alu_op.sub = 1'b1;
            end
            S_GAPW: begin
                w_alu_op.a = r_tmp;
                w_alu_op.b = TOP_W'(3);
            end
            S_BUMP: begin
                w_alu_op.a = r_aln;
                w_alu_op.b = TOP_W'({r_words, 2'b00});
            end
            S_CHK: begin
                w_alu_op.a   = {1'b0, r_heap_limit};
                w_alu_op.b   = r_top;
                w_alu_op.sub = 1'b1;
            end
            default: begin
                w_alu_op = '0;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_top     = r_top;
        n_aln     = r_aln;
        n_tmp     = r_tmp;
        n_words   = r_words;
        n_amask   = r_amask;
        n_dropped = r_dropped;
        n_result  = r_result;
        n_status  = r_status;
        w_we      = 1'b0;
        w_waddr   = IDX_W'(r_cnt);
        w_wentry  = '0;
        w_raddr   = r_idx;

        unique case (r_state)
            S_IDLE: begin
                w_raddr = IDX_W'(r_cnt - CNT_W'(1));
                if (w_in_acc) begin
                    n_words   = w_words;
                    n_amask   = w_amask;
                    n_dropped = 1'b0;
                    n_result  = '0;
                    n_status  = ST_OK;
                    n_idx     = IDX_W'(r_cnt - CNT_W'(1));
                    case (i_cmd)
                        CMD_FREE: begin
                            n_state = S_OUT;
                            if (w_full) begin
                                n_status = ST_DROP;
                            end else begin
                                w_we          = 1'b1;
                                w_wentry.addr = i_block_address;
                                w_wentry.size = w_words;
                                n_cnt         = r_cnt + CNT_W'(1);
                            end
                        end
                        CMD_INIT: begin
                            n_top   = {1'b0, r_heap_start};
                            n_state = S_OUT;
                        end
                        default: begin
                            n_state = (r_cnt == '0) ? S_ALIGN : S_SRCH;
                        end
                    endcase
                end
            end
            S_SRCH: begin
                if (w_hit) begin
                    n_result = w_rentry.addr;
                    w_raddr  = IDX_W'(r_idx + IDX_W'(1));
                    if (w_tail) begin
                        n_state = S_SHIFT;
                    end else begin
                        n_cnt   = r_cnt - CNT_W'(1);
                        n_state = S_OUT;
                    end
                end else if (r_idx == '0) begin
                    n_state = S_ALIGN;
                end else begin
                    w_raddr = IDX_W'(r_idx - IDX_W'(1));
                    n_idx   = IDX_W'(r_idx - IDX_W'(1));
                end
            end
            S_SHIFT: begin
                // The read data holds the entry just above r_idx.
                w_we     = 1'b1;
                w_waddr  = r_idx;
                w_wentry = w_rentry;
                w_raddr  = IDX_W'(r_idx + IDX_W'(2));
                n_idx    = IDX_W'(r_idx + IDX_W'(1));
                if (!w_more) begin
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = S_OUT;
                end
            end
            S_ALIGN: begin
                n_aln   = w_alu_res.sum & ~{1'b0, r_amask};
                n_state = S_GAP;
            end
            S_GAP: begin
                n_tmp   = w_alu_res.sum;
                n_state = (w_alu_res.sum == '0) ? S_BUMP : S_GAPW;
            end
            S_GAPW: begin
                // The alignment gap below the aligned address goes back to the table unless the table is full.
                if (w_full) begin
                    n_dropped = 1'b1;
                end else begin
                    w_we          = 1'b1;
                    w_wentry.addr = r_top[ADDR_W-1:0];
                    w_wentry.size = w_alu_res.sum[SIZE_W+1:2];
                    n_cnt         = r_cnt + CNT_W'(1);
                end
                n_state = S_BUMP;
            end
            S_BUMP: begin
                n_top   = w_alu_res.sum;
                n_state = S_CHK;
            end
            S_CHK: begin
                // No carry from limit - top means the top has passed the limit.
                if (!w_alu_res.carry) begin
                    n_result = '0;
                    n_status = ST_OOM;
                end else begin
                    n_result = r_aln[ADDR_W-1:0];
                    n_status = r_dropped ? ST_DROP : ST_OK;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_top        <= '0;
            r_heap_start <= '0;
            r_heap_limit <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_top   <= n_top;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HEAP_START: r_heap_start <= i_cfg_data;
                    CFG_HEAP_LIMIT: r_heap_limit <= i_cfg_data;
                    default:        r_heap_start <= r_heap_start;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_aln     <= n_aln;
        r_tmp     <= n_tmp;
        r_words   <= n_words;
        r_amask   <= n_amask;
        r_dropped <= n_dropped;
        r_result  <= n_result;
        r_status  <= n_status;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(FREE_SLOTS))
        else $error("free table fill count above its depth");

    a_oom_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_OOM) |-> (o_result_address == '0))
        else $error("out of memory result carries an address");

    a_full_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_cmd == CMD_FREE) && w_full |=> (r_cnt == $past(r_cnt)))
        else $error("free into a full table changed the fill count");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != S_IDLE))
        else $error("accepted request did not start work");

    a_free_init_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && ((i_cmd == CMD_FREE) || (i_cmd == CMD_INIT)) |=> o_out_valid)
        else $error("free or init result not presented in the next cycle");

endmodule
